[design/gpc_pkg.sv]
// Shared constants, codes and types for the pointer gesture classifier.
`timescale 1ns / 1ps

package gpc_pkg;

   localparam int COORD_BITS_DEFAULT = 16;

   localparam int MODE_BITS = 3;
   localparam int GEST_BITS = 3;
   localparam int CFG_DATA_BITS = 12;
   localparam int CFG_INDEX_BITS = 3;
   localparam int DIST_BITS = 12;
   localparam int GEN_BITS = 4;
   localparam int TH_SQ_BITS = 2 * DIST_BITS;

   // Event kinds.
   localparam logic [MODE_BITS-1:0] MODE_DOWN = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_MOVE = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_UP   = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_LOST = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_MENU = 3'd4;

   // Gesture codes.
   localparam logic [GEST_BITS-1:0] GEST_NONE   = 3'd0;
   localparam logic [GEST_BITS-1:0] GEST_LEFT   = 3'd1;
   localparam logic [GEST_BITS-1:0] GEST_RIGHT  = 3'd2;
   localparam logic [GEST_BITS-1:0] GEST_LSHAPE = 3'd3;
   localparam logic [GEST_BITS-1:0] GEST_REVL   = 3'd4;

   // Bits of the gesture enable register.
   localparam int GEN_LEFT_BIT   = 0;
   localparam int GEN_RIGHT_BIT  = 1;
   localparam int GEN_LSHAPE_BIT = 2;
   localparam int GEN_REVL_BIT   = 3;

   // Register indexes.
   localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_ENABLE   = 3'd0;
   localparam logic [CFG_INDEX_BITS-1:0] REG_DRAG_THRESHOLD = 3'd1;
   localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_DOWN       = 3'd2;
   localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_GESTURE    = 3'd3;
   localparam logic [CFG_INDEX_BITS-1:0] REG_GESTURE_EN     = 3'd4;

   // Register reset values.
   localparam logic                   RST_BLOCK_ENABLE   = 1'b1;
   localparam logic [DIST_BITS-1:0]   RST_DRAG_THRESHOLD = 12'd5;
   localparam logic [DIST_BITS-1:0]   RST_MIN_DOWN       = 12'd50;
   localparam logic [DIST_BITS-1:0]   RST_MIN_GESTURE    = 12'd50;
   localparam logic [GEN_BITS-1:0]    RST_GESTURE_EN     = 4'hF;
   localparam logic [TH_SQ_BITS-1:0]  RST_DRAG_TH_SQ     = 24'd25;

   typedef struct packed {
      logic                  block_enable;
      logic [DIST_BITS-1:0]  min_down_distance;
      logic [DIST_BITS-1:0]  min_gesture_distance;
      logic [GEN_BITS-1:0]   gesture_enables;
      logic [TH_SQ_BITS-1:0] drag_th_sq;
   } cfg_type;

   typedef struct packed {
      logic                 handled;
      logic [GEST_BITS-1:0] gesture;
      logic                 plain_click;
      logic                 tracking_active;
   } result_type;

endpackage

[design/gpc_ifs.sv]
// Valid/ready channel interfaces for pointer events and classification results.
`timescale 1ns / 1ps

interface gpc_req_if #(
   parameter int COORD_BITS = gpc_pkg::COORD_BITS_DEFAULT
) ();
   logic                               valid;
   logic                               ready;
   logic [gpc_pkg::MODE_BITS-1:0]      mode;
   logic signed [COORD_BITS-1:0]       pos_x;
   logic signed [COORD_BITS-1:0]       pos_y;

   modport source (output valid, mode, pos_x, pos_y, input ready);
   modport sink (input valid, mode, pos_x, pos_y, output ready);
endinterface

interface gpc_rsp_if ();
   logic                          valid;
   logic                          ready;
   logic                          handled;
   logic [gpc_pkg::GEST_BITS-1:0] gesture;
   logic                          plain_click;
   logic                          tracking_active;

   modport source (output valid, handled, gesture, plain_click, tracking_active, input ready);
   modport sink (input valid, handled, gesture, plain_click, tracking_active, output ready);
endinterface

[design/gpc_cfg_regs.sv]
// Configuration register file with the squared drag threshold kept alongside.
`timescale 1ns / 1ps

module gpc_cfg_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [gpc_pkg::CFG_INDEX_BITS-1:0]  csr_index,
   input  logic [gpc_pkg::CFG_DATA_BITS-1:0]   csr_wr_data,
   output gpc_pkg::cfg_type                    cfg
);

   logic                               block_enable_ff, block_enable_in;
   logic [gpc_pkg::DIST_BITS-1:0]      min_down_ff, min_down_in;
   logic [gpc_pkg::DIST_BITS-1:0]      min_gesture_ff, min_gesture_in;
   logic [gpc_pkg::GEN_BITS-1:0]       gesture_en_ff, gesture_en_in;
   logic [gpc_pkg::TH_SQ_BITS-1:0]     drag_th_sq_ff, drag_th_sq_in;
   logic [gpc_pkg::DIST_BITS-1:0]      wr_dist;
   logic [gpc_pkg::TH_SQ_BITS-1:0]     wr_dist_wide;

   assign wr_dist      = csr_wr_data[gpc_pkg::DIST_BITS-1:0];
   assign wr_dist_wide = {{(gpc_pkg::TH_SQ_BITS-gpc_pkg::DIST_BITS){1'b0}}, wr_dist};

   always_comb begin
      block_enable_in = block_enable_ff;
      min_down_in     = min_down_ff;
      min_gesture_in  = min_gesture_ff;
      gesture_en_in   = gesture_en_ff;
      drag_th_sq_in   = drag_th_sq_ff;
      if (csr_wr_en) begin
         case (csr_index)
            gpc_pkg::REG_BLOCK_ENABLE:   block_enable_in = csr_wr_data[0];
            // Only the square of the threshold is ever compared against.
            gpc_pkg::REG_DRAG_THRESHOLD: drag_th_sq_in = wr_dist_wide * wr_dist_wide;
            gpc_pkg::REG_MIN_DOWN:       min_down_in = wr_dist;
            gpc_pkg::REG_MIN_GESTURE:    min_gesture_in = wr_dist;
            gpc_pkg::REG_GESTURE_EN:     gesture_en_in = csr_wr_data[gpc_pkg::GEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_enable_ff <= gpc_pkg::RST_BLOCK_ENABLE;
         min_down_ff     <= gpc_pkg::RST_MIN_DOWN;
         min_gesture_ff  <= gpc_pkg::RST_MIN_GESTURE;
         gesture_en_ff   <= gpc_pkg::RST_GESTURE_EN;
         drag_th_sq_ff   <= gpc_pkg::RST_DRAG_TH_SQ;
      end else begin
         block_enable_ff <= block_enable_in;
         min_down_ff     <= min_down_in;
         min_gesture_ff  <= min_gesture_in;
         gesture_en_ff   <= gesture_en_in;
         drag_th_sq_ff   <= drag_th_sq_in;
      end
   end

   assign cfg.block_enable         = block_enable_ff;
   assign cfg.min_down_distance    = min_down_ff;
   assign cfg.min_gesture_distance = min_gesture_ff;
   assign cfg.gesture_enables      = gesture_en_ff;
   assign cfg.drag_th_sq           = drag_th_sq_ff;

endmodule

[design/gpc_engine.sv]
// Tracking state and the per-event classification logic.
`timescale 1ns / 1ps

module gpc_engine #(
   parameter int COORD_BITS = gpc_pkg::COORD_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           fire,
   input  logic [gpc_pkg::MODE_BITS-1:0]  mode,
   input  logic signed [COORD_BITS-1:0]   pos_x,
   input  logic signed [COORD_BITS-1:0]   pos_y,
   input  gpc_pkg::cfg_type               cfg,
   output gpc_pkg::result_type            result
);

   localparam int DW  = COORD_BITS + 1;
   localparam int CW  = (DW + 1 > gpc_pkg::DIST_BITS + 2) ? DW + 1 : gpc_pkg::DIST_BITS + 2;
   localparam int SQW = (2 * DW + 1 > gpc_pkg::TH_SQ_BITS + 1) ? 2 * DW + 1
                                                               : gpc_pkg::TH_SQ_BITS + 1;
   localparam int RW  = DW + 2;

   logic                         tracking_ff, tracking_in;
   logic signed [COORD_BITS-1:0] origin_x_ff, origin_x_in;
   logic signed [COORD_BITS-1:0] origin_y_ff, origin_y_in;
   logic signed [DW-1:0]         max_dn_ff, max_dn_in;
   logic                         dragged_ff, dragged_in;
   logic                         went_down_ff, went_down_in;

   logic signed [DW-1:0]         dx, dy, max_upd;
   logic [DW-1:0]                ax, ay;
   logic [2*DW-1:0]              ax_sq, ay_sq;
   logic [SQW-1:0]               dist_sq, th_sq;
   logic signed [CW-1:0]         dx_c, mg_c, max_c, mdd_c;
   logic [CW-1:0]                ax_u, mg_u;
   logic [RW-1:0]                two_ax, three_ay;
   logic                         is_drag, is_down, ratio_ok;
   logic [gpc_pkg::GEST_BITS-1:0] gest;

   // Displacement from the start point, one bit wider than a coordinate.
   assign dx = $signed({pos_x[COORD_BITS-1], pos_x}) - $signed({origin_x_ff[COORD_BITS-1], origin_x_ff});
   assign dy = $signed({pos_y[COORD_BITS-1], pos_y}) - $signed({origin_y_ff[COORD_BITS-1], origin_y_ff});
   assign ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
   assign ay = dy[DW-1] ? DW'(-dy) : DW'(dy);

   assign ax_sq   = ax * ax;
   assign ay_sq   = ay * ay;
   assign dist_sq = SQW'(ax_sq) + SQW'(ay_sq);
   assign th_sq   = SQW'(cfg.drag_th_sq);
   assign is_drag = dist_sq > th_sq;

   assign max_upd = (dy > max_dn_ff) ? dy : max_dn_ff;
   assign max_c   = $signed({{(CW-DW){max_upd[DW-1]}}, max_upd});
   assign mdd_c   = $signed({{(CW-gpc_pkg::DIST_BITS){1'b0}}, cfg.min_down_distance});
   assign is_down = max_c >= mdd_c;

   assign dx_c = $signed({{(CW-DW){dx[DW-1]}}, dx});
   assign mg_u = {{(CW-gpc_pkg::DIST_BITS){1'b0}}, cfg.min_gesture_distance};
   assign mg_c = $signed(mg_u);
   assign ax_u = {{(CW-DW){1'b0}}, ax};

   // The 1.5 aspect ratio test, done exactly as 2|dx| > 3|dy|.
   assign two_ax   = {1'b0, ax, 1'b0};
   assign three_ay = {2'b00, ay} + {1'b0, ay, 1'b0};
   assign ratio_ok = (ax_u >= mg_u) && (two_ax > three_ay);

   always_comb begin
      gest = gpc_pkg::GEST_NONE;
      if (went_down_ff && (dx_c >= mg_c) && cfg.gesture_enables[gpc_pkg::GEN_LSHAPE_BIT]) begin
         gest = gpc_pkg::GEST_LSHAPE;
      end else if (went_down_ff && (dx_c <= -mg_c)
                   && cfg.gesture_enables[gpc_pkg::GEN_REVL_BIT]) begin
         gest = gpc_pkg::GEST_REVL;
      end else if (ratio_ok) begin
         if (dx[DW-1] && cfg.gesture_enables[gpc_pkg::GEN_LEFT_BIT]) begin
            gest = gpc_pkg::GEST_LEFT;
         end else if (!dx[DW-1] && (ax != '0)
                      && cfg.gesture_enables[gpc_pkg::GEN_RIGHT_BIT]) begin
            gest = gpc_pkg::GEST_RIGHT;
         end
      end
   end

   always_comb begin
      tracking_in  = tracking_ff;
      origin_x_in  = origin_x_ff;
      origin_y_in  = origin_y_ff;
      max_dn_in    = max_dn_ff;
      dragged_in   = dragged_ff;
      went_down_in = went_down_ff;
      result.handled     = 1'b0;
      result.gesture     = gpc_pkg::GEST_NONE;
      result.plain_click = 1'b0;
      if (cfg.block_enable) begin
         case (mode)
            gpc_pkg::MODE_DOWN: begin
               tracking_in    = 1'b1;
               dragged_in     = 1'b0;
               went_down_in   = 1'b0;
               max_dn_in      = '0;
               origin_x_in    = pos_x;
               origin_y_in    = pos_y;
               result.handled = 1'b1;
            end
            gpc_pkg::MODE_MOVE: begin
               if (tracking_ff) begin
                  dragged_in     = dragged_ff | is_drag;
                  max_dn_in      = max_upd;
                  went_down_in   = went_down_ff | is_down;
                  result.handled = 1'b1;
               end
            end
            gpc_pkg::MODE_UP: begin
               if (tracking_ff) begin
                  tracking_in        = 1'b0;
                  result.gesture     = gest;
                  result.plain_click = (gest == gpc_pkg::GEST_NONE) && !dragged_ff;
                  result.handled     = 1'b1;
               end
            end
            gpc_pkg::MODE_LOST: begin
               tracking_in = 1'b0;
            end
            gpc_pkg::MODE_MENU: begin
               result.handled = tracking_ff;
            end
            default: ;
         endcase
      end
      result.tracking_active = tracking_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracking_ff  <= 1'b0;
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         max_dn_ff    <= '0;
         dragged_ff   <= 1'b0;
         went_down_ff <= 1'b0;
      end else if (fire) begin
         tracking_ff  <= tracking_in;
         origin_x_ff  <= origin_x_in;
         origin_y_ff  <= origin_y_in;
         max_dn_ff    <= max_dn_in;
         dragged_ff   <= dragged_in;
         went_down_ff <= went_down_in;
      end
   end

endmodule

[design/pointer_gesture_classifier_core.sv]
// Top level of the pointer gesture classifier: input stage, engine and output stage.
//
//   channel  | direction | carries
//   ---------+-----------+---------------------------------------------------
//   req_bus  | in        | mode, pos_x, pos_y (one pointer event per word)
//   rsp_bus  | out       | handled, gesture, plain_click, tracking_active
//   csr_*    | in        | register writes: csr_wr_en, csr_index, csr_wr_data
//
// A result word is presented after its event is accepted: the event
// waits in the input register while the engine evaluates it, and the result
// register loads when the engine fires. One word is accepted per cycle while
// rsp_bus does not stall; the engine state is updated in the same cycle the
// result is registered, so consecutive events see each other's effects.
// A stall on rsp_bus holds the result and backs up into the input register.
// Reset is synchronous and returns the valid flags, engine state and configuration registers to their defaults.
`timescale 1ns / 1ps

module pointer_gesture_classifier_core #(
   parameter int COORD_BITS = gpc_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [gpc_pkg::CFG_INDEX_BITS-1:0]  csr_index,
   input  logic [gpc_pkg::CFG_DATA_BITS-1:0]   csr_wr_data,
   gpc_req_if.sink                             req_bus,
   gpc_rsp_if.source                           rsp_bus
);

   gpc_pkg::cfg_type              cfg;
   gpc_pkg::result_type           result;
   gpc_pkg::result_type           rsp_data_ff;

   logic                          in_vld_ff, in_vld_in;
   logic [gpc_pkg::MODE_BITS-1:0] mode_ff;
   logic signed [COORD_BITS-1:0]  pos_x_ff, pos_y_ff;
   logic                          rsp_vld_ff, rsp_vld_in;
   logic                          advance, fire, take;

   assign advance = !rsp_vld_ff || rsp_bus.ready;
   assign fire    = in_vld_ff && advance;
   assign req_bus.ready = !in_vld_ff || advance;
   assign take    = req_bus.valid && req_bus.ready;

   assign in_vld_in  = take ? 1'b1 : (fire ? 1'b0 : in_vld_ff);
   assign rsp_vld_in = fire ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_vld_ff);

   gpc_cfg_regs u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   gpc_engine #(
      .COORD_BITS (COORD_BITS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .mode   (mode_ff),
      .pos_x  (pos_x_ff),
      .pos_y  (pos_y_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         mode_ff  <= req_bus.mode;
         pos_x_ff <= req_bus.pos_x;
         pos_y_ff <= req_bus.pos_y;
      end
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_bus.valid           = rsp_vld_ff;
   assign rsp_bus.handled         = rsp_data_ff.handled;
   assign rsp_bus.gesture         = rsp_data_ff.gesture;
   assign rsp_bus.plain_click     = rsp_data_ff.plain_click;
   assign rsp_bus.tracking_active = rsp_data_ff.tracking_active;

endmodule

[design/gpc_checker.sv]
// Port-level checks on the classifier's result channel, bound to the top level.
`timescale 1ns / 1ps

module gpc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_handled,
   input logic [gpc_pkg::GEST_BITS-1:0] rsp_gesture,
   input logic                          rsp_plain_click,
   input logic                          rsp_tracking_active
);

   // A stalled result word must hold.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_gesture)
         && $stable(rsp_handled) && $stable(rsp_plain_click) && $stable(rsp_tracking_active))
      else $error("stalled result word changed");

   // A recognized gesture only comes from a consumed release.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_gesture != gpc_pkg::GEST_NONE)
         |-> rsp_handled && !rsp_tracking_active && !rsp_plain_click)
      else $error("gesture reported outside a release");

   // A plain click is a consumed release without a gesture.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_plain_click
         |-> rsp_handled && !rsp_tracking_active && (rsp_gesture == gpc_pkg::GEST_NONE))
      else $error("plain click flagged outside a release");

   // Events passed through carry no gesture and no click.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_handled |-> (rsp_gesture == gpc_pkg::GEST_NONE) && !rsp_plain_click)
      else $error("unhandled event carries a result");

endmodule

bind pointer_gesture_classifier_core gpc_checker u_gpc_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_handled         (rsp_bus.handled),
   .rsp_gesture         (rsp_bus.gesture),
   .rsp_plain_click     (rsp_bus.plain_click),
   .rsp_tracking_active (rsp_bus.tracking_active)
);
